>>> hw/rtl/solar_lighting_supervisor_defines.svh
// ----------------------------------------------------------------------------
// Solar lighting supervisor assertion macros
// Shared concurrent assertion forms for the supervisor checkers.
// ----------------------------------------------------------------------------
`ifndef SOLAR_LIGHTING_SUPERVISOR_DEFINES_SVH
`define SOLAR_LIGHTING_SUPERVISOR_DEFINES_SVH

// clocked assertion, masked during reset
`define SLS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that holds whenever a result item is presented
`define SLS_ASSERT_ON_OUT(lbl, cond, msg) \
  `SLS_ASSERT_CLK(lbl, out_valid_o |-> (cond), msg)

`endif

>>> hw/rtl/sls_pkg.sv
// ----------------------------------------------------------------------------
// Solar lighting supervisor package
// Types, register indices and reset constants shared by the supervisor.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int ADC_BITS_DEF   = 12;
  localparam int TIMER_BITS_DEF = 24;
  localparam int DET_W          = 24;
  localparam int ELAPSED_W      = 16;
  localparam int CFG_IDX_W      = 3;

  localparam int RST_MORNING  = 2000;
  localparam int RST_NIGHT    = 1000;
  localparam int RST_START    = 2500;
  localparam int RST_DET_TIME = 60000;
  localparam int RST_BAT_LOW  = 2800;
  localparam int RST_BAT_HIGH = 3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MORNING  = 3'd0,
    REG_NIGHT    = 3'd1,
    REG_START    = 3'd2,
    REG_DET_TIME = 3'd3,
    REG_BAT_LOW  = 3'd4,
    REG_BAT_HIGH = 3'd5,
    REG_LI_MODE  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLASS_MORNING  = 2'd0,
    CLASS_UNSTABLE = 2'd1,
    CLASS_NIGHT    = 2'd2
  } light_class_e;

  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_DIM    = 2'd1,
    LVL_BRIGHT = 2'd2
  } lighting_e;

  typedef struct packed {
    light_class_e cls;
    logic         flag;
  } day_st_t;

endpackage

>>> hw/rtl/sls_daylight.sv
// ----------------------------------------------------------------------------
// Daylight qualifier
// Classes the panel sample and qualifies the daylight flag with a timer.
// ----------------------------------------------------------------------------
module sls_daylight import sls_pkg::*; #(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  day_st_t                st_i,
  input  logic [TIMER_BITS-1:0]  timer_i,
  input  logic [ELAPSED_W-1:0]   elapsed_i,
  input  logic [ADC_BITS-1:0]    panel_i,
  input  logic                   rest_i,
  input  logic [ADC_BITS-1:0]    morning_thr_i,
  input  logic [ADC_BITS-1:0]    night_thr_i,
  input  logic [DET_W-1:0]       det_time_i,
  output day_st_t                st_o,
  output logic [TIMER_BITS-1:0]  timer_o
);

  localparam int CMP_W = (TIMER_BITS > DET_W) ? TIMER_BITS : DET_W;

  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] sat;
  logic [CMP_W-1:0]      timer_wide;
  logic [CMP_W-1:0]      det_wide;
  light_class_e          cls;

  assign sum        = {1'b0, timer_i} + (TIMER_BITS+1)'(elapsed_i);
  assign sat        = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
  assign timer_wide = CMP_W'(timer_i);
  assign det_wide   = CMP_W'(det_time_i);

  always_comb begin
    if (panel_i > morning_thr_i) begin
      cls = CLASS_MORNING;
    end else if (panel_i < night_thr_i) begin
      cls = CLASS_NIGHT;
    end else begin
      cls = CLASS_UNSTABLE;
    end
  end

  always_comb begin
    st_o    = st_i;
    timer_o = timer_i;
    if (timer_wide <= det_wide) begin
      timer_o = sat;
    end else if (st_i.cls != CLASS_UNSTABLE) begin
      st_o.flag = (st_i.cls == CLASS_MORNING);
    end
    if (rest_i) begin
      if (cls != st_i.cls || cls == CLASS_UNSTABLE) begin
        timer_o = '0;
      end
      st_o.cls = cls;
    end
  end

endmodule

>>> hw/rtl/solar_lighting_supervisor.sv
// ----------------------------------------------------------------------------
// Solar lighting supervisor
// Per-tick daylight qualification, lighting, load, charger and current control.
// ----------------------------------------------------------------------------
// One input item is one control tick. It is taken into an input register, the
// whole tick is evaluated in one pass and the result lands in an output
// register, so a result is presented after the input and output registers, and
// one item can be accepted every cycle without a stall. Each tick updates the
// light class, qualify timer, daylight flag, lighting level and current
// select. The output register holds a result until taken; meanwhile the input
// register takes one more item and then the input stalls. Configuration writes
// take effect at once and are expected only while no item is in flight.
module solar_lighting_supervisor import sls_pkg::*; #(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  localparam int CFG_W     = (ADC_BITS > DET_W) ? ADC_BITS : DET_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ELAPSED_W-1:0]  elapsed_ms_i,
  input  logic [ADC_BITS-1:0]   panel_adc_i,
  input  logic [ADC_BITS-1:0]   battery_adc_i,
  input  logic                  presence_i,
  input  logic                  rest_ended_i,
  input  logic                  charger_halted_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            lighting_level_o,
  output logic                  load_on_o,
  output logic                  charger_start_o,
  output logic                  fast_charge_o,
  output logic                  daylight_o,
  output logic                  restart_schedule_o
);

  // configuration
  logic [ADC_BITS-1:0] morning_thr_q, night_thr_q, start_thr_q;
  logic [ADC_BITS-1:0] bat_low_q, bat_high_q;
  logic [DET_W-1:0]    det_time_q;
  logic                li_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      morning_thr_q <= ADC_BITS'(RST_MORNING);
      night_thr_q   <= ADC_BITS'(RST_NIGHT);
      start_thr_q   <= ADC_BITS'(RST_START);
      det_time_q    <= DET_W'(RST_DET_TIME);
      bat_low_q     <= ADC_BITS'(RST_BAT_LOW);
      bat_high_q    <= ADC_BITS'(RST_BAT_HIGH);
      li_mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MORNING:  morning_thr_q <= cfg_wdata_i[ADC_BITS-1:0];
        REG_NIGHT:    night_thr_q   <= cfg_wdata_i[ADC_BITS-1:0];
        REG_START:    start_thr_q   <= cfg_wdata_i[ADC_BITS-1:0];
        REG_DET_TIME: det_time_q    <= cfg_wdata_i[DET_W-1:0];
        REG_BAT_LOW:  bat_low_q     <= cfg_wdata_i[ADC_BITS-1:0];
        REG_BAT_HIGH: bat_high_q    <= cfg_wdata_i[ADC_BITS-1:0];
        REG_LI_MODE:  li_mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 s1_valid_q, s1_valid_d, s1_adv, in_acc;
  logic [ELAPSED_W-1:0] s1_elapsed_q;
  logic [ADC_BITS-1:0]  s1_panel_q, s1_battery_q;
  logic                 s1_presence_q, s1_rest_q, s1_stopped_q;
  logic                 out_valid_q, out_valid_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_elapsed_q  <= elapsed_ms_i;
      s1_panel_q    <= panel_adc_i;
      s1_battery_q  <= battery_adc_i;
      s1_presence_q <= presence_i;
      s1_rest_q     <= rest_ended_i;
      s1_stopped_q  <= charger_halted_i;
    end
  end

  // tick evaluation
  day_st_t               day_q, day_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  lighting_e             lvl_q, lvl_d;
  logic                  cur_q, cur_d;
  logic                  restart_d, start_d, load_d;

  sls_daylight #(
    .ADC_BITS   (ADC_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_daylight (
    .st_i          (day_q),
    .timer_i       (timer_q),
    .elapsed_i     (s1_elapsed_q),
    .panel_i       (s1_panel_q),
    .rest_i        (s1_rest_q),
    .morning_thr_i (morning_thr_q),
    .night_thr_i   (night_thr_q),
    .det_time_i    (det_time_q),
    .st_o          (day_d),
    .timer_o       (timer_d)
  );

  always_comb begin
    lvl_d     = lvl_q;
    restart_d = 1'b0;
    if (lvl_d != LVL_OFF && day_d.flag) begin
      lvl_d = LVL_OFF;
    end
    if (lvl_d == LVL_OFF && !day_d.flag) begin
      lvl_d     = LVL_DIM;
      restart_d = 1'b1;
    end
    if (s1_presence_q && lvl_d == LVL_DIM) begin
      lvl_d = LVL_BRIGHT;
    end
    if (!s1_presence_q && lvl_d == LVL_BRIGHT) begin
      lvl_d = LVL_DIM;
    end
  end

  assign start_d = s1_stopped_q && (s1_panel_q > start_thr_q) && s1_rest_q;
  assign load_d  = (lvl_d != LVL_OFF);

  always_comb begin
    cur_d = cur_q;
    if (li_mode_q) begin
      if (s1_battery_q < bat_low_q) begin
        cur_d = 1'b0;
      end
      if (s1_battery_q > bat_high_q) begin
        cur_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      day_q       <= '{cls: CLASS_UNSTABLE, flag: 1'b1};
      timer_q     <= '0;
      lvl_q       <= LVL_OFF;
      cur_q       <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        day_q   <= day_d;
        timer_q <= timer_d;
        lvl_q   <= lvl_d;
        cur_q   <= cur_d;
      end
    end
  end

  // result register
  logic [1:0] out_lvl_q;
  logic       out_load_q, out_start_q, out_cur_q, out_day_q, out_restart_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_lvl_q     <= lvl_d;
      out_load_q    <= load_d;
      out_start_q   <= start_d;
      out_cur_q     <= cur_d;
      out_day_q     <= day_d.flag;
      out_restart_q <= restart_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign lighting_level_o   = out_lvl_q;
  assign load_on_o          = out_load_q;
  assign charger_start_o    = out_start_q;
  assign fast_charge_o      = out_cur_q;
  assign daylight_o         = out_day_q;
  assign restart_schedule_o = out_restart_q;

endmodule

>>> hw/rtl/sls_checker.sv
// ----------------------------------------------------------------------------
// Solar lighting supervisor checker
// Port-level assertions, bound to the supervisor top level.
// ----------------------------------------------------------------------------
`include "solar_lighting_supervisor_defines.svh"

module sls_checker import sls_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] lighting_level_o,
  input logic       load_on_o,
  input logic       restart_schedule_o
);

  // a stalled result item holds
  `SLS_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(lighting_level_o) && $stable(load_on_o), "result item changed while stalled")
  // load tracks lighting
  `SLS_ASSERT_ON_OUT(a_load_follows, load_on_o == (lighting_level_o != LVL_OFF), "load does not follow lighting")
  // a schedule restart only comes with lighting on
  `SLS_ASSERT_ON_OUT(a_restart_lit, !restart_schedule_o || lighting_level_o != LVL_OFF, "restart without lighting")
  // empty result register never blocks the input
  `SLS_ASSERT_CLK(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with no result pending")

endmodule

bind solar_lighting_supervisor sls_checker u_sls_checker (.*);

>>> test/solar_lighting_supervisor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solar lighting supervisor checker
// Watches the configuration port and both item channels. It keeps its own
// copy of the supervisor state and works out the result of every accepted
// tick, then compares each delivered result with the oldest one still due.
// ----------------------------------------------------------------------------
module solar_lighting_supervisor_checker import sls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DET_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ELAPSED_W-1:0]  elapsed_ms_i,
  input  logic [ADC_BITS_DEF-1:0] panel_adc_i,
  input  logic [ADC_BITS_DEF-1:0] battery_adc_i,
  input  logic                  presence_i,
  input  logic                  rest_ended_i,
  input  logic                  charger_halted_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            lighting_level_i,
  input  logic                  load_on_i,
  input  logic                  charger_start_i,
  input  logic                  fast_charge_i,
  input  logic                  daylight_i,
  input  logic                  restart_schedule_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  localparam int ADC_W = ADC_BITS_DEF;
  localparam int TMR_W = TIMER_BITS_DEF;

  typedef struct packed {
    lighting_e level;
    logic      load;
    logic      start;
    logic      high_cur;
    logic      day;
    logic      restart;
  } tick_result_t;

  logic [ADC_W-1:0] morning_lvl, night_lvl, start_lvl, bat_low_lvl, bat_high_lvl;
  logic [DET_W-1:0] det_ms;
  logic             li_mode;

  light_class_e     cls_q;
  logic [TMR_W-1:0] qual_ms;
  logic             day_q;
  lighting_e        level_q;
  logic             load_q;
  logic             high_cur_q;

  tick_result_t     due_results[$];

  task automatic report(input string what, input int got, input int want);
    mismatch_count_o++;
    $display("%0t ns mismatch: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic supervise_tick(input logic [ELAPSED_W-1:0] elapsed,
                                input logic [ADC_W-1:0] panel,
                                input logic [ADC_W-1:0] battery,
                                input logic presence, input logic rest,
                                input logic stopped, output tick_result_t r);
    logic [TMR_W:0] sum;
    light_class_e   cls;
    logic           restart;
    logic           start;
    restart = 1'b0;
    start   = 1'b0;
    // daylight qualification
    if (qual_ms <= det_ms) begin
      sum     = {1'b0, qual_ms} + (TMR_W+1)'(elapsed);
      qual_ms = sum[TMR_W] ? '1 : sum[TMR_W-1:0];
    end else if (cls_q != CLASS_UNSTABLE) begin
      day_q = (cls_q == CLASS_MORNING);
    end
    if (rest) begin
      if (panel > morning_lvl) cls = CLASS_MORNING;
      else if (panel < night_lvl) cls = CLASS_NIGHT;
      else cls = CLASS_UNSTABLE;
      if (cls != cls_q || cls == CLASS_UNSTABLE) qual_ms = '0;
      cls_q = cls;
    end
    // lighting rules, in order
    if (level_q != LVL_OFF && day_q) level_q = LVL_OFF;
    if (level_q == LVL_OFF && !day_q) begin
      level_q = LVL_DIM;
      restart = 1'b1;
    end
    if (presence && level_q == LVL_DIM) level_q = LVL_BRIGHT;
    if (!presence && level_q == LVL_BRIGHT) level_q = LVL_DIM;
    if (stopped && panel > start_lvl && rest) start = 1'b1;
    load_q = (level_q != LVL_OFF);
    if (li_mode) begin
      if (battery < bat_low_lvl) high_cur_q = 1'b0;
      if (battery > bat_high_lvl) high_cur_q = 1'b1;
    end
    r.level    = level_q;
    r.load     = load_q;
    r.start    = start;
    r.high_cur = high_cur_q;
    r.day      = day_q;
    r.restart  = restart;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    tick_result_t nxt;
    if (!rst_ni) begin
      morning_lvl      = ADC_W'(RST_MORNING);
      night_lvl        = ADC_W'(RST_NIGHT);
      start_lvl        = ADC_W'(RST_START);
      det_ms           = DET_W'(RST_DET_TIME);
      bat_low_lvl      = ADC_W'(RST_BAT_LOW);
      bat_high_lvl     = ADC_W'(RST_BAT_HIGH);
      li_mode          = 1'b0;
      cls_q            = CLASS_UNSTABLE;
      qual_ms          = '0;
      day_q            = 1'b1;
      level_q          = LVL_OFF;
      load_q           = 1'b0;
      high_cur_q       = 1'b1;
      mismatch_count_o = 0;
      due_results.delete();
      pending_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MORNING:  morning_lvl  = cfg_wdata_i[ADC_W-1:0];
          REG_NIGHT:    night_lvl    = cfg_wdata_i[ADC_W-1:0];
          REG_START:    start_lvl    = cfg_wdata_i[ADC_W-1:0];
          REG_DET_TIME: det_ms       = cfg_wdata_i;
          REG_BAT_LOW:  bat_low_lvl  = cfg_wdata_i[ADC_W-1:0];
          REG_BAT_HIGH: bat_high_lvl = cfg_wdata_i[ADC_W-1:0];
          REG_LI_MODE:  li_mode      = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report("result with nothing due", 1, 0);
        end else begin
          want = due_results.pop_front();
          if (lighting_level_i !== want.level)
            report("lighting_level", int'(lighting_level_i), int'(want.level));
          if (load_on_i !== want.load)
            report("load_on", int'(load_on_i), int'(want.load));
          if (charger_start_i !== want.start)
            report("charger_start", int'(charger_start_i), int'(want.start));
          if (fast_charge_i !== want.high_cur)
            report("fast_charge", int'(fast_charge_i), int'(want.high_cur));
          if (daylight_i !== want.day)
            report("daylight", int'(daylight_i), int'(want.day));
          if (restart_schedule_i !== want.restart)
            report("restart_schedule", int'(restart_schedule_i), int'(want.restart));
        end
      end
      if (in_valid_i && in_ready_i) begin
        supervise_tick(elapsed_ms_i, panel_adc_i, battery_adc_i, presence_i,
                       rest_ended_i, charger_halted_i, nxt);
        due_results.push_back(nxt);
      end
      pending_o = due_results.size();
    end
  end

endmodule

>>> test/solar_lighting_supervisor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solar lighting supervisor testbench
// Drives control ticks in bursts against a stalling receiver, through a
// directed set of daylight, lighting, charger and current cases and then
// random phases under several register settings, extremes included. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module solar_lighting_supervisor_tb import sls_pkg::*;;

  typedef struct packed {
    logic [ELAPSED_W-1:0]    elapsed;
    logic [ADC_BITS_DEF-1:0] panel;
    logic [ADC_BITS_DEF-1:0] battery;
    logic                    presence;
    logic                    rest;
    logic                    stopped;
  } tick_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_e;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx    = '0;
  logic [DET_W-1:0]        cfg_wdata  = '0;
  logic                    tick_valid = 1'b0;
  logic                    tick_ready;
  logic [ELAPSED_W-1:0]    elapsed_ms = '0;
  logic [ADC_BITS_DEF-1:0] panel_adc  = '0;
  logic [ADC_BITS_DEF-1:0] battery_adc = '0;
  logic                    presence   = 1'b0;
  logic                    rest_ended = 1'b0;
  logic                    charger_halted = 1'b0;
  logic                    res_valid;
  logic                    res_ready  = 1'b0;
  logic [1:0]              lighting_level;
  logic                    load_on;
  logic                    charger_start;
  logic                    fast_charge;
  logic                    daylight;
  logic                    restart_schedule;

  int     mismatches;
  int     pending;

  int     burst_left = 0;
  bit     tick_held  = 1'b0;
  bit     hold_mode  = 1'b0;
  int     run_left   = 0;
  int     run_kind   = 0;
  int     morning_lvl, night_lvl, start_lvl, bat_low_lvl, bat_high_lvl;
  stall_e stall_mode = STALL_NONE;
  int     stall_left = 0;

  solar_lighting_supervisor dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (tick_valid),
    .in_ready_o            (tick_ready),
    .elapsed_ms_i          (elapsed_ms),
    .panel_adc_i           (panel_adc),
    .battery_adc_i         (battery_adc),
    .presence_i            (presence),
    .rest_ended_i          (rest_ended),
    .charger_halted_i      (charger_halted),
    .out_valid_o           (res_valid),
    .out_ready_i           (res_ready),
    .lighting_level_o      (lighting_level),
    .load_on_o             (load_on),
    .charger_start_o       (charger_start),
    .fast_charge_o         (fast_charge),
    .daylight_o            (daylight),
    .restart_schedule_o    (restart_schedule)
  );

  solar_lighting_supervisor_checker u_check (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (tick_valid),
    .in_ready_i            (tick_ready),
    .elapsed_ms_i          (elapsed_ms),
    .panel_adc_i           (panel_adc),
    .battery_adc_i         (battery_adc),
    .presence_i            (presence),
    .rest_ended_i          (rest_ended),
    .charger_halted_i      (charger_halted),
    .out_valid_i           (res_valid),
    .out_ready_i           (res_ready),
    .lighting_level_i      (lighting_level),
    .load_on_i             (load_on),
    .charger_start_i       (charger_start),
    .fast_charge_i         (fast_charge),
    .daylight_i            (daylight),
    .restart_schedule_i    (restart_schedule),
    .mismatch_count_o      (mismatches),
    .pending_o             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("solar_lighting_supervisor_tb: FAIL");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(10, 120);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  res_ready <= 1'b1;
      STALL_COIN:  res_ready <= 1'($urandom_range(0, 1));
      STALL_HEAVY: res_ready <= ($urandom_range(0, 3) == 0);
      default:     res_ready <= ~res_ready;
    endcase
  end

  function automatic int clamp_adc(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  function automatic tick_t mk(input int e, input int p, input int b,
                               input bit pr, input bit r, input bit s);
    tick_t t;
    t.elapsed  = ELAPSED_W'(e);
    t.panel    = ADC_BITS_DEF'(p);
    t.battery  = ADC_BITS_DEF'(b);
    t.presence = pr;
    t.rest     = r;
    t.stopped  = s;
    return t;
  endfunction

  // wait until every result due has been taken
  task automatic wait_idle();
    if (tick_held) begin
      tick_valid <= 1'b0;
      tick_held = 1'b0;
    end
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= DET_W'(val);
    @(negedge clk);
  endtask

  task automatic apply_settings(input int morning, input int night, input int start,
                                input int det, input int bat_low, input int bat_high,
                                input bit li);
    wait_idle();
    morning_lvl  = morning;
    night_lvl    = night;
    start_lvl    = start;
    bat_low_lvl  = bat_low;
    bat_high_lvl = bat_high;
    write_reg(REG_MORNING, morning);
    write_reg(REG_NIGHT, night);
    write_reg(REG_START, start);
    write_reg(REG_DET_TIME, det);
    write_reg(REG_BAT_LOW, bat_low);
    write_reg(REG_BAT_HIGH, bat_high);
    write_reg(REG_LI_MODE, int'(li));
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings(input bit li, input int det_hi);
    int m, n, lo, hi;
    m  = $urandom_range(0, 4095);
    n  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, m);
    lo = $urandom_range(0, 4095);
    hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(lo, 4095);
    apply_settings(m, n, $urandom_range(0, 4095), $urandom_range(0, det_hi), lo, hi, li);
  endtask

  // sender pacing: bursts with random gaps, and now and then a full drain
  task automatic pace();
    int gap;
    if ($urandom_range(0, 199) == 0) begin
      wait_idle();
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        tick_valid <= 1'b0;
        tick_held = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_tick(input tick_t t);
    tick_valid      <= 1'b1;
    elapsed_ms      <= t.elapsed;
    panel_adc       <= t.panel;
    battery_adc     <= t.battery;
    presence        <= t.presence;
    rest_ended      <= t.rest;
    charger_halted  <= t.stopped;
    tick_held = 1'b1;
    do @(posedge clk); while (!tick_ready);
    @(negedge clk);
    pace();
  endtask

  // panel runs hold one light class long enough to qualify
  function automatic tick_t rand_tick();
    tick_t t;
    if (run_left == 0) begin
      run_kind = $urandom_range(0, 3);
      run_left = $urandom_range(1, 40);
    end
    run_left--;
    if (hold_mode) begin
      t.elapsed = ELAPSED_W'(65535 - int'($urandom_range(0, 255)));
      t.panel   = ADC_BITS_DEF'(4095 - int'($urandom_range(0, 15)));
      t.rest    = ($urandom_range(0, 31) == 0);
    end else begin
      case ($urandom_range(0, 9))
        0:       t.elapsed = ELAPSED_W'($urandom_range(0, 65535));
        1, 2:    t.elapsed = ELAPSED_W'($urandom_range(0, 1000));
        default: t.elapsed = ELAPSED_W'($urandom_range(0, 64));
      endcase
      case (run_kind)
        0: t.panel = ADC_BITS_DEF'(clamp_adc(morning_lvl + int'($urandom_range(1, 300))));
        1: t.panel = ADC_BITS_DEF'(clamp_adc(night_lvl - int'($urandom_range(1, 300))));
        2: t.panel = ADC_BITS_DEF'($urandom_range(night_lvl, morning_lvl));
        default: t.panel = ADC_BITS_DEF'($urandom_range(0, 4095));
      endcase
      t.rest = ($urandom_range(0, 4) != 0);
    end
    case ($urandom_range(0, 4))
      0, 1:    t.battery = ADC_BITS_DEF'(clamp_adc(bat_low_lvl
                                                   + int'($urandom_range(0, 100)) - 50));
      2, 3:    t.battery = ADC_BITS_DEF'(clamp_adc(bat_high_lvl
                                                   + int'($urandom_range(0, 100)) - 50));
      default: t.battery = ADC_BITS_DEF'($urandom_range(0, 4095));
    endcase
    t.presence = 1'($urandom_range(0, 1));
    t.stopped  = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_tick(rand_tick());
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short detection time: night, dim, bright, unstable, morning, current
    apply_settings(2000, 1000, 2500, 3, 2800, 3000, 1'b1);
    send_tick(mk(0, 0, 0, 0, 0, 0));
    send_tick(mk(65535, 4095, 4095, 1, 1, 1));
    send_tick(mk(2, 0, 2900, 0, 1, 0));
    send_tick(mk(2, 0, 2900, 0, 1, 0));
    send_tick(mk(2, 0, 2900, 0, 1, 0));
    send_tick(mk(1, 0, 2900, 1, 1, 0));
    send_tick(mk(1, 0, 2900, 1, 1, 0));
    send_tick(mk(1, 0, 2900, 0, 1, 0));
    send_tick(mk(0, 1500, 2900, 0, 1, 0));
    send_tick(mk(5, 1500, 2900, 0, 0, 0));
    send_tick(mk(0, 1500, 2900, 0, 0, 0));
    send_tick(mk(0, 2001, 2900, 0, 1, 0));
    send_tick(mk(4, 2001, 2900, 0, 1, 0));
    send_tick(mk(4, 2001, 2900, 0, 1, 0));
    send_tick(mk(4, 2001, 2801, 0, 1, 1));
    send_tick(mk(0, 2500, 2799, 0, 1, 1));
    send_tick(mk(0, 2501, 2799, 0, 0, 1));
    send_tick(mk(0, 2501, 3001, 0, 1, 1));

    // crossed thresholds, detection time out of the timer's reach
    apply_settings(500, 3000, 0, 'hFFFFFF, 3000, 2800, 1'b1);
    send_tick(mk(65535, 1000, 2900, 0, 1, 1));
    send_tick(mk(65535, 3500, 2900, 1, 1, 0));
    send_tick(mk(100, 200, 4095, 0, 1, 0));
    send_tick(mk(0, 0, 0, 0, 1, 1));

    // lead-acid: current select holds
    apply_settings(2000, 1000, 2500, 0, 2800, 3000, 1'b0);
    send_tick(mk(0, 0, 0, 0, 1, 0));
    send_tick(mk(65535, 4095, 4095, 1, 1, 1));

    apply_settings(RST_MORNING, RST_NIGHT, RST_START, $urandom_range(0, 300),
                   RST_BAT_LOW, RST_BAT_HIGH, 1'b1);
    run_random(350);
    random_settings(1'b1, 300);
    run_random(350);
    apply_settings(4095, 0, 4095, 0, 0, 4095, 1'b1);
    run_random(150);
    apply_settings(0, 4095, 0, 0, 4095, 0, 1'b1);
    run_random(150);
    random_settings(1'b0, 300);
    run_random(350);
    random_settings(1'($urandom_range(0, 1)), 5000);
    run_random(300);

    // long steady morning: the timer runs into saturation
    apply_settings(2000, 1000, 2500, 'hFFFFFF, 2800, 3000, 1'b0);
    hold_mode = 1'b1;
    run_random(300);

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("solar_lighting_supervisor_tb: PASS");
    end else begin
      $display("solar_lighting_supervisor_tb: FAIL");
    end
    $finish;
  end

endmodule
